FILE: src/ksp_pkg.sv
// Shared types, codes and constants for the keyed slot pool.
`default_nettype none

package ksp_pkg;

  localparam int SLOTS_DEF     = 32;
  localparam int REF_BITS_DEF  = 16;
  localparam int KEY_BITS      = 256;
  localparam int KEY_WORD_BITS = 64;
  localparam int STAMP_BITS    = 64;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_FREE     = 3'd1;
  localparam logic [2:0] ST_EVICT    = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_RELEASED = 3'd4;

  typedef struct packed {
    logic                     cmd;
    logic [KEY_WORD_BITS-1:0] key_word0;
    logic [KEY_WORD_BITS-1:0] key_word1;
    logic [KEY_WORD_BITS-1:0] key_word2;
    logic [KEY_WORD_BITS-1:0] key_word3;
    logic [4:0]               release_slot;
  } req_t;

  typedef struct packed {
    logic [4:0]  granted_slot;
    logic [2:0]  status;
    logic [15:0] ref_count;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REL,
    S_SCAN,
    S_PICK
  } state_t;

  typedef struct packed {
    logic hit;
    logic free;
    logic older;
  } cmp_t;

endpackage

`default_nettype wire

FILE: src/keyed_slot_pool_lru_refcount_core.sv
// Top level: sequencer, slot state and result register of the keyed slot pool.
`default_nettype none

// One word at a time. A release reads its slot record and gives its result
// from S_REL (straight from idle if the index is out of range). An acquire
// scans the slot records one per cycle through the single read port of the
// record memory and the shared compare unit: a hit at slot s ends the scan
// there, otherwise the grant, eviction or overflow result comes from S_PICK
// after the last slot. busy is high while a word is in work; the result is
// shown for exactly one cycle with strobe, and the receiver cannot stall it.
module keyed_slot_pool_lru_refcount_core #(
  parameter int SLOTS    = ksp_pkg::SLOTS_DEF,
  parameter int REF_BITS = ksp_pkg::REF_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire ksp_pkg::req_t req,
  output logic               busy,
  output logic               strobe,
  output ksp_pkg::rsp_t      rsp
);

  localparam int IW    = $clog2(SLOTS);
  localparam int XW    = IW + 5;
  localparam int SW    = ksp_pkg::STAMP_BITS;
  localparam int KW    = ksp_pkg::KEY_BITS;
  localparam int REC_W = KW + REF_BITS + SW;
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  ksp_pkg::state_t state, state_next;
  ksp_pkg::req_t   item;
  ksp_pkg::rsp_t   rsp_next;
  ksp_pkg::cmp_t   cmp;

  logic [SLOTS-1:0]    slot_valid;
  logic [SW-1:0]       use_clock;
  logic [IW-1:0]       cmp_idx;
  logic                have_free;
  logic [IW-1:0]       free_at;
  logic                have_old;
  logic [IW-1:0]       old_at;
  logic [SW-1:0]       old_stamp;

  logic                accept;
  logic                emit;
  logic                tick;
  logic                set_valid;
  logic                we;
  logic [IW-1:0]       wr_addr;
  logic [REC_W-1:0]    wr_data;
  logic [IW-1:0]       rd_addr;
  logic [REC_W-1:0]    rd_data;

  logic [XW-1:0]       req_idx_x;
  logic [XW-1:0]       item_idx_x;
  logic                req_in_range;
  logic [IW-1:0]       req_idx;
  logic [IW-1:0]       item_idx;
  logic [IW-1:0]       cur_idx;
  logic [IW-1:0]       pick_idx;
  logic                slot_ok;
  logic                last;
  logic [KW-1:0]       item_key;
  logic [KW-1:0]       rd_key;
  logic [REF_BITS-1:0] rd_refs;
  logic [SW-1:0]       rd_stamp;
  logic [REF_BITS-1:0] cur_refs;
  logic [REF_BITS-1:0] refs_inc;
  logic [REF_BITS-1:0] refs_dec;
  logic [SW-1:0]       stamp_new;

  function automatic logic [4:0] slot5(input logic [IW-1:0] i);
    logic [XW-1:0] w;
    w = XW'(i);
    return w[4:0];
  endfunction

  function automatic logic [15:0] cnt16(input logic [REF_BITS-1:0] r);
    logic [REF_BITS+15:0] w;
    w = (REF_BITS + 16)'(r);
    return w[15:0];
  endfunction

  assign busy   = (state != ksp_pkg::S_IDLE);
  assign accept = start && !busy;

  assign req_idx_x    = XW'(req.release_slot);
  assign item_idx_x   = XW'(item.release_slot);
  assign req_in_range = (req_idx_x < XW'(SLOTS));
  assign req_idx      = req_idx_x[IW-1:0];
  assign item_idx     = item_idx_x[IW-1:0];
  assign cur_idx      = (state == ksp_pkg::S_REL) ? item_idx : cmp_idx;
  assign pick_idx     = have_free ? free_at : old_at;
  assign slot_ok      = slot_valid[cur_idx];
  assign last         = ((IW + 1)'(cmp_idx) == (IW + 1)'(SLOTS - 1));

  assign item_key  = {item.key_word0, item.key_word1, item.key_word2, item.key_word3};
  assign rd_key    = rd_data[REC_W-1 -: KW];
  assign rd_refs   = rd_data[SW +: REF_BITS];
  assign rd_stamp  = rd_data[SW-1:0];
  assign cur_refs  = slot_ok ? rd_refs : '0;
  assign refs_inc  = (cur_refs == REF_MAX) ? cur_refs : cur_refs + REF_BITS'(1);
  assign refs_dec  = (cur_refs == '0) ? cur_refs : cur_refs - REF_BITS'(1);
  assign stamp_new = use_clock + SW'(1);

  ksp_slot_mem #(
    .DEPTH (SLOTS),
    .WIDTH (REC_W)
  ) u_mem (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ksp_cmp_unit #(
    .REF_BITS (REF_BITS)
  ) u_cmp (
    .slot_ok    (slot_ok),
    .slot_key   (rd_key),
    .slot_refs  (rd_refs),
    .slot_stamp (rd_stamp),
    .key        (item_key),
    .have_old   (have_old),
    .old_stamp  (old_stamp),
    .res        (cmp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ksp_pkg::S_IDLE: begin
        if (accept) begin
          if (req.cmd == ksp_pkg::CMD_RELEASE) begin
            state_next = req_in_range ? ksp_pkg::S_REL : ksp_pkg::S_IDLE;
          end else begin
            state_next = ksp_pkg::S_SCAN;
          end
        end
      end
      ksp_pkg::S_REL: state_next = ksp_pkg::S_IDLE;
      ksp_pkg::S_SCAN: begin
        if (cmp.hit) begin
          state_next = ksp_pkg::S_IDLE;
        end else if (last) begin
          state_next = ksp_pkg::S_PICK;
        end
      end
      ksp_pkg::S_PICK: state_next = ksp_pkg::S_IDLE;
      default: state_next = ksp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    we        = 1'b0;
    wr_addr   = cur_idx;
    wr_data   = {rd_key, refs_inc, stamp_new};
    emit      = 1'b0;
    tick      = 1'b0;
    set_valid = 1'b0;
    rd_addr   = cmp_idx + IW'(1);
    rsp_next  = '{granted_slot: slot5(cur_idx), status: ksp_pkg::ST_HIT,
                  ref_count: cnt16(refs_inc)};
    unique case (state)
      ksp_pkg::S_IDLE: begin
        rd_addr = (req.cmd == ksp_pkg::CMD_RELEASE) ? req_idx : '0;
        if (accept && (req.cmd == ksp_pkg::CMD_RELEASE) && !req_in_range) begin
          emit     = 1'b1;
          rsp_next = '{granted_slot: req.release_slot, status: ksp_pkg::ST_RELEASED,
                       ref_count: 16'd0};
        end
      end
      ksp_pkg::S_REL: begin
        we       = 1'b1;
        wr_data  = {rd_key, refs_dec, stamp_new};
        tick     = 1'b1;
        emit     = 1'b1;
        rsp_next = '{granted_slot: slot5(item_idx), status: ksp_pkg::ST_RELEASED,
                     ref_count: cnt16(refs_dec)};
      end
      ksp_pkg::S_SCAN: begin
        if (cmp.hit) begin
          we   = 1'b1;
          tick = 1'b1;
          emit = 1'b1;
        end
      end
      ksp_pkg::S_PICK: begin
        tick    = 1'b1;
        emit    = 1'b1;
        wr_addr = pick_idx;
        wr_data = {item_key, REF_BITS'(1), stamp_new};
        if (have_free || have_old) begin
          we        = 1'b1;
          set_valid = 1'b1;
          rsp_next  = '{granted_slot: slot5(pick_idx),
                        status: have_free ? ksp_pkg::ST_FREE : ksp_pkg::ST_EVICT,
                        ref_count: 16'd1};
        end else begin
          rsp_next = '{granted_slot: 5'd0, status: ksp_pkg::ST_OVERFLOW, ref_count: 16'd0};
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ksp_pkg::S_IDLE;
      slot_valid <= '0;
      use_clock  <= '0;
      strobe     <= 1'b0;
      cmp_idx    <= '0;
      have_free  <= 1'b0;
      have_old   <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
      if (tick) begin
        use_clock <= stamp_new;
      end
      if (set_valid) begin
        slot_valid[pick_idx] <= 1'b1;
      end
      if (accept) begin
        cmp_idx   <= '0;
        have_free <= 1'b0;
        have_old  <= 1'b0;
      end else if ((state == ksp_pkg::S_SCAN) && !cmp.hit) begin
        cmp_idx <= cmp_idx + IW'(1);
        if (cmp.free && !have_free) begin
          have_free <= 1'b1;
        end
        if (cmp.older) begin
          have_old <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    if (emit) begin
      rsp <= rsp_next;
    end
    if ((state == ksp_pkg::S_SCAN) && cmp.free && !have_free) begin
      free_at <= cmp_idx;
    end
    if ((state == ksp_pkg::S_SCAN) && cmp.older) begin
      old_at    <= cmp_idx;
      old_stamp <= rd_stamp;
    end
  end

endmodule

`default_nettype wire

FILE: src/ksp_slot_mem.sv
// Slot record memory: one write port, one registered read port.
`default_nettype none

module ksp_slot_mem #(
  parameter int DEPTH = ksp_pkg::SLOTS_DEF,
  parameter int WIDTH = ksp_pkg::KEY_BITS + ksp_pkg::REF_BITS_DEF + ksp_pkg::STAMP_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: src/ksp_cmp_unit.sv
// Shared per-slot compare unit: key match, free test and LRU stamp compare.
`default_nettype none

module ksp_cmp_unit #(
  parameter int REF_BITS = ksp_pkg::REF_BITS_DEF
) (
  input  wire logic                            slot_ok,
  input  wire logic [ksp_pkg::KEY_BITS-1:0]    slot_key,
  input  wire logic [REF_BITS-1:0]             slot_refs,
  input  wire logic [ksp_pkg::STAMP_BITS-1:0]  slot_stamp,
  input  wire logic [ksp_pkg::KEY_BITS-1:0]    key,
  input  wire logic                            have_old,
  input  wire logic [ksp_pkg::STAMP_BITS-1:0]  old_stamp,
  output ksp_pkg::cmp_t                        res
);

  always_comb begin
    res.hit   = slot_ok && (slot_key == key);
    res.free  = !slot_ok;
    res.older = slot_ok && (slot_refs == '0) && (!have_old || (slot_stamp < old_stamp));
  end

endmodule

`default_nettype wire

FILE: src/ksp_checker.sv
// Port-level checks for the keyed slot pool, bound to the top level.
`default_nettype none

module ksp_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire ksp_pkg::req_t req,
  input wire logic          busy,
  input wire logic          strobe,
  input wire ksp_pkg::rsp_t rsp
);

  a_acq_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.cmd == ksp_pkg::CMD_ACQUIRE)) |=> busy)
    else $error("acquire word did not start a scan");

  a_res_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy)
    else $error("result shown while a word is still in work");

  a_busy_src: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  a_ovf: assert property (@(posedge clk) disable iff (rst)
    (strobe && (rsp.status == ksp_pkg::ST_OVERFLOW)) |->
      ((rsp.granted_slot == 5'd0) && (rsp.ref_count == 16'd0)))
    else $error("overflow result carries a slot or count");

  a_new_one: assert property (@(posedge clk) disable iff (rst)
    (strobe && ((rsp.status == ksp_pkg::ST_FREE) || (rsp.status == ksp_pkg::ST_EVICT))) |->
      (rsp.ref_count == 16'd1))
    else $error("new slot count not one");

endmodule

bind keyed_slot_pool_lru_refcount_core ksp_checker u_ksp_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .req    (req),
  .busy   (busy),
  .strobe (strobe),
  .rsp    (rsp)
);

`default_nettype wire
